>>> hdl/size_class_free_block_cache_defines.svh
// assertion macros for the size class free block cache checker
// expects clk, rst_n, out_valid and out_stall in the scope of use
`ifndef SIZE_CLASS_FREE_BLOCK_CACHE_DEFINES_SVH
`define SIZE_CLASS_FREE_BLOCK_CACHE_DEFINES_SVH

// general property check, disabled while in reset
`define SCFBC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scfbc: property failed");

// a result signal holds while the result item is stalled
`define SCFBC_ASSERT_HELD(label, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (out_valid && out_stall) |=> $stable(sig)) \
        else $error("scfbc: stalled result item changed");

`endif

>>> hdl/scfbc_pkg.sv
// shared types and constants of the size class free block cache
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scfbc_pkg;

    localparam int UNIT_SHIFT = 3;
    localparam int SIZE_W     = 32;
    localparam int IDX_W      = SIZE_W - UNIT_SHIFT;
    localparam int CLS_W      = 16;
    localparam int BYTES_W    = 33;
    localparam int TOT_W      = 23;
    localparam int LIMIT_W    = 22;
    localparam int MARK_W     = 32;
    localparam int Q_DEPTH    = 2;

    localparam logic [CLS_W-1:0]   UNCACHED    = 16'hFFFF;
    localparam logic [MARK_W-1:0]  HDR_MARK    = 32'hACCEDEAD;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 22'd2097152;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_COLLECT = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ALLOC_HIT    = 3'd0,
        ST_ALLOC_MISS   = 3'd1,
        ST_FREE_CACHED  = 3'd2,
        ST_FREE_RELEASE = 3'd3,
        ST_NULL_IGNORED = 3'd4,
        ST_BAD_MARK     = 3'd5,
        ST_COLLECTED    = 3'd6
    } status_t;

    // what the back end has to do with an item
    typedef enum logic [1:0] {
        KIND_ALLOC,
        KIND_FREE,
        KIND_COLLECT,
        KIND_DONE
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        status_t            status;
        logic [CLS_W-1:0]   cls;
        logic [CLS_W-1:0]   size_class;
        logic [BYTES_W-1:0] block_bytes;
    } item_ctrl_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC,
        BK_ALLOC_HEAD,
        BK_ALLOC_POP,
        BK_FREE_ISSUE,
        BK_FREE_LINK,
        BK_REPORT
    } back_state_t;

endpackage

`default_nettype wire

>>> hdl/scfbc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module scfbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, data holds while not read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/scfbc_front.sv
// front end: classifies an incoming item into the work for the back end
// depends on scfbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module scfbc_front #(
    parameter int NUM_CLASSES = 8192,
    parameter int HANDLE_BITS = 48
) (
    input  wire logic [1:0]                   opcode,
    input  wire logic [scfbc_pkg::SIZE_W-1:0] req_size,
    input  wire logic [HANDLE_BITS-1:0]       block_handle,
    input  wire logic [scfbc_pkg::CLS_W-1:0]  block_class,
    input  wire logic [scfbc_pkg::MARK_W-1:0] block_mark,
    output scfbc_pkg::item_ctrl_t             ctrl
);

    logic [scfbc_pkg::SIZE_W-1:0] size_m1;
    logic [scfbc_pkg::IDX_W-1:0]  idx;
    logic [scfbc_pkg::IDX_W:0]    idx_p2;
    logic                         idx_in_range;
    logic                         cls_in_range;

    // size to class and miss byte count
    always_comb
    begin
        size_m1      = req_size - scfbc_pkg::SIZE_W'(1);
        idx          = (req_size == '0) ? '0 : size_m1[scfbc_pkg::SIZE_W-1:scfbc_pkg::UNIT_SHIFT];
        idx_p2       = {1'b0, idx} + (scfbc_pkg::IDX_W+1)'(2);
        idx_in_range = ({{scfbc_pkg::UNIT_SHIFT{1'b0}}, idx} < 32'(NUM_CLASSES));
        cls_in_range = ({16'd0, block_class} < 32'(NUM_CLASSES));
    end

    // classification
    always_comb
    begin
        ctrl             = '0;
        ctrl.kind        = scfbc_pkg::KIND_DONE;
        ctrl.status      = scfbc_pkg::ST_NULL_IGNORED;
        case (scfbc_pkg::opcode_t'(opcode))
            scfbc_pkg::OP_ALLOC:
            begin
                ctrl.status      = scfbc_pkg::ST_ALLOC_MISS;
                ctrl.block_bytes = {idx_p2, {scfbc_pkg::UNIT_SHIFT{1'b0}}};
                if (idx_in_range)
                begin
                    ctrl.kind       = scfbc_pkg::KIND_ALLOC;
                    ctrl.cls        = idx[scfbc_pkg::CLS_W-1:0];
                    ctrl.size_class = idx[scfbc_pkg::CLS_W-1:0];
                end
                else
                begin
                    ctrl.size_class = scfbc_pkg::UNCACHED;
                end
            end
            scfbc_pkg::OP_FREE:
            begin
                if (block_handle == '0)
                begin
                    ctrl.status = scfbc_pkg::ST_NULL_IGNORED;
                end
                else if (block_mark != scfbc_pkg::HDR_MARK)
                begin
                    ctrl.status = scfbc_pkg::ST_BAD_MARK;
                end
                else if (!cls_in_range)
                begin
                    ctrl.status = scfbc_pkg::ST_FREE_RELEASE;
                end
                else
                begin
                    ctrl.kind   = scfbc_pkg::KIND_FREE;
                    ctrl.status = scfbc_pkg::ST_FREE_CACHED;
                    ctrl.cls    = block_class;
                end
            end
            scfbc_pkg::OP_COLLECT:
            begin
                ctrl.kind   = scfbc_pkg::KIND_COLLECT;
                ctrl.status = scfbc_pkg::ST_COLLECTED;
            end
            default:
            begin
                ctrl.status = scfbc_pkg::ST_NULL_IGNORED;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/scfbc_queue.sv
// short item queue between front end and back end
// depends on scfbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module scfbc_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(scfbc_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(scfbc_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [scfbc_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // flags and pointer update
    always_comb
    begin
        full        = (count_reg == CNT_W'(scfbc_pkg::Q_DEPTH));
        empty       = (count_reg == '0);
        pop_data    = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(scfbc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(scfbc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/scfbc_back.sv
// back end: class list memories, flush sweep and result register
// depends on scfbc_pkg and scfbc_ram
`timescale 1ns / 1ps
`default_nettype none

module scfbc_back #(
    parameter int NUM_CLASSES = 8192,
    parameter int NUM_ENTRIES = 2048,
    parameter int HANDLE_BITS = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [scfbc_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  wire logic                          q_empty,
    input  wire scfbc_pkg::item_ctrl_t         q_ctrl,
    input  wire logic [HANDLE_BITS-1:0]        q_handle,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [HANDLE_BITS-1:0]             out_handle,
    output logic [scfbc_pkg::CLS_W-1:0]        size_class,
    output logic [scfbc_pkg::BYTES_W-1:0]      block_bytes,
    output logic                               cache_flushed,
    output logic [scfbc_pkg::TOT_W-1:0]        flushed_units,
    output logic [scfbc_pkg::TOT_W-1:0]        cached_units
);

    localparam int CW        = $clog2(NUM_CLASSES);
    localparam int EW        = $clog2(NUM_ENTRIES);
    localparam int PW        = $clog2(NUM_ENTRIES + 1);
    localparam int SWEEP_LEN = (NUM_CLASSES > NUM_ENTRIES) ? NUM_CLASSES : NUM_ENTRIES;
    localparam int SWW       = $clog2(SWEEP_LEN);
    localparam int SWP       = SWW + 1;
    localparam int TW        = scfbc_pkg::TOT_W;

    scfbc_pkg::back_state_t state_reg, state_next;
    logic [SWW-1:0]                 cnt_reg, cnt_next;
    logic                           init_reg, init_next;
    scfbc_pkg::item_ctrl_t          cur_ctrl_reg, cur_ctrl_next;
    logic [HANDLE_BITS-1:0]         cur_handle_reg, cur_handle_next;
    logic [PW-1:0]                  free_head_reg, free_head_next;
    logic [TW-1:0]                  total_reg, total_next;
    logic [scfbc_pkg::LIMIT_W-1:0]  limit_reg;
    logic [PW-1:0]                  hit_head_reg, hit_head_next;
    logic                           flushed_reg, flushed_next;
    logic [TW-1:0]                  fu_reg, fu_next;

    // result register
    logic                           out_valid_reg, out_valid_next;
    logic [2:0]                     status_reg, status_next;
    logic [HANDLE_BITS-1:0]         out_handle_reg, out_handle_next;
    logic [scfbc_pkg::CLS_W-1:0]    size_class_reg, size_class_next;
    logic [scfbc_pkg::BYTES_W-1:0]  block_bytes_reg, block_bytes_next;
    logic                           cache_flushed_reg, cache_flushed_next;
    logic [TW-1:0]                  flushed_units_reg, flushed_units_next;
    logic [TW-1:0]                  cached_units_reg, cached_units_next;
    logic                           out_load;

    // memory ports
    logic                   head_we, head_re;
    logic [CW-1:0]          head_waddr, head_raddr;
    logic [PW-1:0]          head_wdata, head_rdata;
    logic                   next_we, next_re;
    logic [EW-1:0]          next_waddr, next_raddr;
    logic [PW-1:0]          next_wdata, next_rdata;
    logic                   hdl_we, hdl_re;
    logic [EW-1:0]          hdl_waddr, hdl_raddr;
    logic [HANDLE_BITS-1:0] hdl_rdata;

    logic          out_free;
    logic          flush_cond;
    logic [CW-1:0] cur_cls;
    logic [EW-1:0] fh_entry;
    logic [TW-1:0] cls_units;

    scfbc_ram #(.WIDTH(PW), .DEPTH(NUM_CLASSES)) u_head_ram (
        .clk     (clk),
        .wr_en   (head_we),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_en   (head_re),
        .rd_addr (head_raddr),
        .rd_data (head_rdata)
    );

    scfbc_ram #(.WIDTH(PW), .DEPTH(NUM_ENTRIES)) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_waddr),
        .wr_data (next_wdata),
        .rd_en   (next_re),
        .rd_addr (next_raddr),
        .rd_data (next_rdata)
    );

    scfbc_ram #(.WIDTH(HANDLE_BITS), .DEPTH(NUM_ENTRIES)) u_handle_ram (
        .clk     (clk),
        .wr_en   (hdl_we),
        .wr_addr (hdl_waddr),
        .wr_data (cur_handle_reg),
        .rd_en   (hdl_re),
        .rd_addr (hdl_raddr),
        .rd_data (hdl_rdata)
    );

    // helpers
    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        cur_cls    = cur_ctrl_reg.cls[CW-1:0];
        fh_entry   = EW'(free_head_reg - PW'(1));
        cls_units  = TW'(cur_cls) + TW'(2);
        flush_cond = (free_head_reg == '0) || (free_head_reg > PW'(NUM_ENTRIES))
                     || ({1'b0, limit_reg} <= total_reg);
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        init_next          = init_reg;
        cur_ctrl_next      = cur_ctrl_reg;
        cur_handle_next    = cur_handle_reg;
        free_head_next     = free_head_reg;
        total_next         = total_reg;
        hit_head_next      = hit_head_reg;
        flushed_next       = flushed_reg;
        fu_next            = fu_reg;
        q_pop              = 1'b0;
        out_load           = 1'b0;
        status_next        = status_reg;
        out_handle_next    = '0;
        size_class_next    = '0;
        block_bytes_next   = '0;
        cache_flushed_next = 1'b0;
        flushed_units_next = '0;
        cached_units_next  = total_reg;
        head_we            = 1'b0;
        head_re            = 1'b0;
        head_waddr         = cur_cls;
        head_raddr         = cur_cls;
        head_wdata         = '0;
        next_we            = 1'b0;
        next_re            = 1'b0;
        next_waddr         = fh_entry;
        next_raddr         = fh_entry;
        next_wdata         = '0;
        hdl_we             = 1'b0;
        hdl_re             = 1'b0;
        hdl_waddr          = fh_entry;
        hdl_raddr          = fh_entry;

        case (state_reg)
            scfbc_pkg::BK_CLEAR:
            begin
                // empty every class list and chain the whole pool in order
                head_we    = ({1'b0, cnt_reg} < SWP'(NUM_CLASSES));
                head_waddr = cnt_reg[CW-1:0];
                head_wdata = '0;
                next_we    = ({1'b0, cnt_reg} < SWP'(NUM_ENTRIES));
                next_waddr = cnt_reg[EW-1:0];
                next_wdata = ({1'b0, cnt_reg} < SWP'(NUM_ENTRIES - 1))
                             ? PW'(cnt_reg) + PW'(2) : '0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == SWW'(SWEEP_LEN - 1))
                begin
                    cnt_next = '0;
                    if (!init_reg)
                    begin
                        init_next  = 1'b1;
                        state_next = scfbc_pkg::BK_IDLE;
                    end
                    else
                    begin
                        free_head_next = PW'(1);
                        total_next     = '0;
                        state_next     = (cur_ctrl_reg.kind == scfbc_pkg::KIND_COLLECT)
                                         ? scfbc_pkg::BK_REPORT : scfbc_pkg::BK_FREE_ISSUE;
                    end
                end
            end
            scfbc_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    cur_ctrl_next   = q_ctrl;
                    cur_handle_next = q_handle;
                    flushed_next    = 1'b0;
                    fu_next         = '0;
                    state_next      = scfbc_pkg::BK_EXEC;
                end
            end
            scfbc_pkg::BK_EXEC:
            begin
                case (cur_ctrl_reg.kind)
                    scfbc_pkg::KIND_ALLOC:
                    begin
                        head_re    = 1'b1;
                        state_next = scfbc_pkg::BK_ALLOC_HEAD;
                    end
                    scfbc_pkg::KIND_FREE:
                    begin
                        if (flush_cond)
                        begin
                            fu_next      = total_reg;
                            flushed_next = 1'b1;
                            cnt_next     = '0;
                            state_next   = scfbc_pkg::BK_CLEAR;
                        end
                        else
                        begin
                            state_next = scfbc_pkg::BK_FREE_ISSUE;
                        end
                    end
                    scfbc_pkg::KIND_COLLECT:
                    begin
                        fu_next      = total_reg;
                        flushed_next = 1'b1;
                        cnt_next     = '0;
                        state_next   = scfbc_pkg::BK_CLEAR;
                    end
                    default:
                    begin
                        // answer fixed by the front end
                        if (out_free)
                        begin
                            out_load         = 1'b1;
                            status_next      = cur_ctrl_reg.status;
                            size_class_next  = cur_ctrl_reg.size_class;
                            block_bytes_next = cur_ctrl_reg.block_bytes;
                            state_next       = scfbc_pkg::BK_IDLE;
                        end
                    end
                endcase
            end
            scfbc_pkg::BK_ALLOC_HEAD:
            begin
                if ((head_rdata != '0) && (head_rdata <= PW'(NUM_ENTRIES)))
                begin
                    hit_head_next = head_rdata;
                    next_re       = 1'b1;
                    next_raddr    = EW'(head_rdata - PW'(1));
                    hdl_re        = 1'b1;
                    hdl_raddr     = EW'(head_rdata - PW'(1));
                    state_next    = scfbc_pkg::BK_ALLOC_POP;
                end
                else if (out_free)
                begin
                    out_load         = 1'b1;
                    status_next      = scfbc_pkg::ST_ALLOC_MISS;
                    size_class_next  = cur_ctrl_reg.size_class;
                    block_bytes_next = cur_ctrl_reg.block_bytes;
                    state_next       = scfbc_pkg::BK_IDLE;
                end
            end
            scfbc_pkg::BK_ALLOC_POP:
            begin
                // unlink the head entry and return it to the pool
                if (out_free)
                begin
                    head_we           = 1'b1;
                    head_wdata        = next_rdata;
                    next_we           = 1'b1;
                    next_waddr        = EW'(hit_head_reg - PW'(1));
                    next_wdata        = free_head_reg;
                    free_head_next    = hit_head_reg;
                    total_next        = total_reg - cls_units;
                    out_load          = 1'b1;
                    status_next       = scfbc_pkg::ST_ALLOC_HIT;
                    out_handle_next   = hdl_rdata;
                    cached_units_next = total_reg - cls_units;
                    state_next        = scfbc_pkg::BK_IDLE;
                end
            end
            scfbc_pkg::BK_FREE_ISSUE:
            begin
                head_re    = 1'b1;
                next_re    = 1'b1;
                state_next = scfbc_pkg::BK_FREE_LINK;
            end
            scfbc_pkg::BK_FREE_LINK:
            begin
                // take the pool head and push it on the class list
                if (out_free)
                begin
                    next_we            = 1'b1;
                    next_wdata         = head_rdata;
                    head_we            = 1'b1;
                    head_wdata         = free_head_reg;
                    hdl_we             = 1'b1;
                    free_head_next     = next_rdata;
                    total_next         = total_reg + cls_units;
                    out_load           = 1'b1;
                    status_next        = scfbc_pkg::ST_FREE_CACHED;
                    cache_flushed_next = flushed_reg;
                    flushed_units_next = fu_reg;
                    cached_units_next  = total_reg + cls_units;
                    state_next         = scfbc_pkg::BK_IDLE;
                end
            end
            scfbc_pkg::BK_REPORT:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    status_next        = scfbc_pkg::ST_COLLECTED;
                    cache_flushed_next = 1'b1;
                    flushed_units_next = fu_reg;
                    state_next         = scfbc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = scfbc_pkg::BK_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scfbc_pkg::BK_CLEAR;
            cnt_reg       <= '0;
            init_reg      <= 1'b0;
            free_head_reg <= '0;
            total_reg     <= '0;
            flushed_reg   <= 1'b0;
            fu_reg        <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= scfbc_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            init_reg      <= init_next;
            free_head_reg <= free_head_next;
            total_reg     <= total_next;
            flushed_reg   <= flushed_next;
            fu_reg        <= fu_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        cur_ctrl_reg   <= cur_ctrl_next;
        cur_handle_reg <= cur_handle_next;
        hit_head_reg   <= hit_head_next;
        if (out_load)
        begin
            status_reg        <= status_next;
            out_handle_reg    <= out_handle_next;
            size_class_reg    <= size_class_next;
            block_bytes_reg   <= block_bytes_next;
            cache_flushed_reg <= cache_flushed_next;
            flushed_units_reg <= flushed_units_next;
            cached_units_reg  <= cached_units_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_handle    = out_handle_reg;
    assign size_class    = size_class_reg;
    assign block_bytes   = block_bytes_reg;
    assign cache_flushed = cache_flushed_reg;
    assign flushed_units = flushed_units_reg;
    assign cached_units  = cached_units_reg;

endmodule

`default_nettype wire

>>> hdl/size_class_free_block_cache.sv
// a flush (collect, first free, full pool or limit reached) sweeps every class list head and pool link:
// one class list head and one pool link written per cycle
// the back end takes one item at a time and finishes it before it pops the next
// reset: asynchronous active low; a clearing pass over every class list head and pool link runs after reset
`timescale 1ns / 1ps
`default_nettype none

module size_class_free_block_cache #(
    parameter int NUM_CLASSES = 8192,
    parameter int NUM_ENTRIES = 2048,
    parameter int HANDLE_BITS = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [scfbc_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [scfbc_pkg::SIZE_W-1:0]  req_size,
    input  wire logic [HANDLE_BITS-1:0]        block_handle,
    input  wire logic [scfbc_pkg::CLS_W-1:0]   block_class,
    input  wire logic [scfbc_pkg::MARK_W-1:0]  block_mark,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [HANDLE_BITS-1:0]             out_handle,
    output logic [scfbc_pkg::CLS_W-1:0]        size_class,
    output logic [scfbc_pkg::BYTES_W-1:0]      block_bytes,
    output logic                               cache_flushed,
    output logic [scfbc_pkg::TOT_W-1:0]        flushed_units,
    output logic [scfbc_pkg::TOT_W-1:0]        cached_units
);

    localparam int CTRL_W = $bits(scfbc_pkg::item_ctrl_t);
    localparam int Q_W    = CTRL_W + HANDLE_BITS;

    scfbc_pkg::item_ctrl_t front_ctrl;
    scfbc_pkg::item_ctrl_t q_ctrl;
    logic [Q_W-1:0]         q_pop_data;
    logic                   q_full, q_empty, q_pop, q_push;

    scfbc_front #(.NUM_CLASSES(NUM_CLASSES), .HANDLE_BITS(HANDLE_BITS)) u_front (
        .opcode       (opcode),
        .req_size     (req_size),
        .block_handle (block_handle),
        .block_class  (block_class),
        .block_mark   (block_mark),
        .ctrl         (front_ctrl)
    );

    // input handshake
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    scfbc_queue #(.WIDTH(Q_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({front_ctrl, block_handle}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    assign q_ctrl = scfbc_pkg::item_ctrl_t'(q_pop_data[Q_W-1:HANDLE_BITS]);

    scfbc_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .NUM_ENTRIES (NUM_ENTRIES),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_empty       (q_empty),
        .q_ctrl        (q_ctrl),
        .q_handle      (q_pop_data[HANDLE_BITS-1:0]),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_handle    (out_handle),
        .size_class    (size_class),
        .block_bytes   (block_bytes),
        .cache_flushed (cache_flushed),
        .flushed_units (flushed_units),
        .cached_units  (cached_units)
    );

endmodule

`default_nettype wire

>>> hdl/scfbc_checker.sv
// port level checker for the size class free block cache, bound to the top level
// depends on scfbc_pkg and size_class_free_block_cache_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "size_class_free_block_cache_defines.svh"

module scfbc_checker #(
    parameter int HANDLE_BITS = 48
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [2:0]                    status,
    input wire logic [HANDLE_BITS-1:0]        out_handle,
    input wire logic [scfbc_pkg::CLS_W-1:0]   size_class,
    input wire logic [scfbc_pkg::BYTES_W-1:0] block_bytes,
    input wire logic                          cache_flushed,
    input wire logic [scfbc_pkg::TOT_W-1:0]   flushed_units,
    input wire logic [scfbc_pkg::TOT_W-1:0]   cached_units
);

    // a stalled result item stays put
    `SCFBC_ASSERT_HELD(a_status_held, status)

    // a collect always empties the cache
    `SCFBC_ASSERT(a_collect_empties, (out_valid && status == scfbc_pkg::ST_COLLECTED) |-> (cache_flushed && cached_units == '0))

    // a hit hands back a block and asks for nothing new
    `SCFBC_ASSERT(a_hit_fields, (out_valid && status == scfbc_pkg::ST_ALLOC_HIT) |-> (size_class == '0 && block_bytes == '0 && !cache_flushed))

    // items that leave the cache alone never flush and never return a handle
    `SCFBC_ASSERT(a_untouched_fields, (out_valid && (status == scfbc_pkg::ST_FREE_RELEASE || status == scfbc_pkg::ST_NULL_IGNORED || status == scfbc_pkg::ST_BAD_MARK)) |-> (!cache_flushed && flushed_units == '0 && out_handle == '0))

endmodule

bind size_class_free_block_cache scfbc_checker #(.HANDLE_BITS(HANDLE_BITS)) u_scfbc_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the size class free block cache
// depends on scfbc_pkg and size_class_free_block_cache
`timescale 1ns / 1ps

module testbench;
    import scfbc_pkg::*;

    localparam int N_CLASSES  = 8192;
    localparam int N_ENTRIES  = 2048;
    localparam int HBITS      = 48;
    localparam int WDOG_LIMIT = 60000;

    typedef struct packed {
        status_t            status;
        logic [HBITS-1:0]   handle;
        logic [CLS_W-1:0]   size_class;
        logic [BYTES_W-1:0] bytes;
        logic               flushed;
        logic [TOT_W-1:0]   flushed_units;
        logic [TOT_W-1:0]   cached_units;
    } answer_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LIMIT_W-1:0]  cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          opcode;
    logic [SIZE_W-1:0]   req_size;
    logic [HBITS-1:0]    block_handle;
    logic [CLS_W-1:0]    block_class;
    logic [MARK_W-1:0]   block_mark;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          status;
    logic [HBITS-1:0]    out_handle;
    logic [CLS_W-1:0]    size_class;
    logic [BYTES_W-1:0]  block_bytes;
    logic                cache_flushed;
    logic [TOT_W-1:0]    flushed_units;
    logic [TOT_W-1:0]    cached_units;

    // mirror of the cache contents
    logic [11:0]         list_head [N_CLASSES];
    logic [HBITS-1:0]    slot_handle [N_ENTRIES];
    logic [11:0]         slot_next [N_ENTRIES];
    logic [11:0]         pool_head;
    logic [TOT_W-1:0]    units_held;
    logic [LIMIT_W-1:0]  limit_units;

    answer_t             pending_answers[$];
    int                  mismatches;
    int                  idle_cycles;
    bit                  quiet_mode;
    int                  out_hold;

    size_class_free_block_cache dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .req_size(req_size), .block_handle(block_handle),
        .block_class(block_class), .block_mark(block_mark),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_handle(out_handle), .size_class(size_class),
        .block_bytes(block_bytes), .cache_flushed(cache_flushed),
        .flushed_units(flushed_units), .cached_units(cached_units)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // empty every list and relink the whole pool
    function automatic logic [TOT_W-1:0] flush_cache();
        logic [TOT_W-1:0] old_units;
        old_units = units_held;
        for (int c = 0; c < N_CLASSES; c++)
            list_head[c] = '0;
        for (int e = 0; e < N_ENTRIES; e++)
            slot_next[e] = (e + 1 < N_ENTRIES) ? 12'(e + 2) : 12'd0;
        pool_head  = 12'd1;
        units_held = '0;
        return old_units;
    endfunction

    // expected answer for one accepted item, updating the mirror
    function automatic answer_t cache_answer(logic [1:0] op, logic [SIZE_W-1:0] sz,
                                             logic [HBITS-1:0] hnd, logic [CLS_W-1:0] cls,
                                             logic [MARK_W-1:0] mark);
        answer_t a;
        logic [IDX_W-1:0] idx;
        logic [11:0] head;
        logic [11:0] nxt;
        int e;
        a = '0;
        a.status = ST_NULL_IGNORED;
        case (opcode_t'(op))
            OP_ALLOC:
            begin
                idx  = (sz == 0) ? '0 : IDX_W'((sz - 1) >> UNIT_SHIFT);
                head = (idx < N_CLASSES) ? list_head[idx] : 12'd0;
                if (head != 0 && head <= N_ENTRIES)
                begin
                    e = head - 1;
                    a.handle       = slot_handle[e];
                    list_head[idx] = slot_next[e];
                    slot_next[e]   = pool_head;
                    pool_head      = head;
                    units_held     = TOT_W'(units_held - (idx + 2));
                    a.status       = ST_ALLOC_HIT;
                end
                else
                begin
                    a.status     = ST_ALLOC_MISS;
                    a.size_class = (idx < N_CLASSES) ? CLS_W'(idx) : UNCACHED;
                    a.bytes      = BYTES_W'((BYTES_W'(idx) + 2) << UNIT_SHIFT);
                end
            end
            OP_FREE:
            begin
                if (hnd == 0)
                    a.status = ST_NULL_IGNORED;
                else if (mark != HDR_MARK)
                    a.status = ST_BAD_MARK;
                else if (cls >= N_CLASSES)
                    a.status = ST_FREE_RELEASE;
                else
                begin
                    if (pool_head == 0 || pool_head > N_ENTRIES ||
                        units_held >= limit_units)
                    begin
                        a.flushed_units = flush_cache();
                        a.flushed       = 1'b1;
                    end
                    e = pool_head - 1;
                    nxt             = slot_next[e];
                    slot_next[e]    = list_head[cls];
                    list_head[cls]  = pool_head;
                    slot_handle[e]  = hnd;
                    pool_head       = nxt;
                    units_held      = TOT_W'(units_held + cls + 2);
                    a.status        = ST_FREE_CACHED;
                end
            end
            OP_COLLECT:
            begin
                a.flushed_units = flush_cache();
                a.flushed       = 1'b1;
                a.status        = ST_COLLECTED;
            end
            default:
                a.status = ST_NULL_IGNORED;
        endcase
        a.cached_units = units_held;
        return a;
    endfunction

    // send one item, predict it at acceptance, then maybe idle
    task automatic send_item(logic [1:0] op, logic [SIZE_W-1:0] sz, logic [HBITS-1:0] hnd,
                             logic [CLS_W-1:0] cls, logic [MARK_W-1:0] mark);
        int gap;
        in_valid     <= 1'b1;
        opcode       <= op;
        req_size     <= sz;
        block_handle <= hnd;
        block_class  <= cls;
        block_mark   <= mark;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_answers.push_back(cache_answer(op, sz, hnd, cls, mark));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_units = val;
    endtask

    function automatic logic [HBITS-1:0] rand_handle();
        logic [HBITS-1:0] h;
        h = {$urandom, $urandom};
        if (h == 0)
            h = 1;
        return h;
    endfunction

    // request size that lands in class cls
    function automatic logic [SIZE_W-1:0] size_of_class(int cls);
        return SIZE_W'(cls * 8 + $urandom_range(1, 8));
    endfunction

    // edges of every field and every special answer
    task automatic test_directed();
        send_item(OP_ALLOC, 32'd0, '0, '0, '0);
        send_item(OP_ALLOC, 32'hFFFF_FFFF, '0, '0, '0);
        send_item(OP_ALLOC, 32'd65536, '0, '0, '0);
        send_item(OP_ALLOC, 32'd65537, '0, '0, '0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, '1, '1, '1);
        send_item(OP_FREE, '0, '0, 16'd3, HDR_MARK);
        send_item(OP_FREE, '0, 48'h1234, 16'd3, ~HDR_MARK);
        send_item(OP_FREE, '0, 48'h1234, UNCACHED, HDR_MARK);
        send_item(OP_FREE, '0, 48'h1234, 16'd8192, HDR_MARK);
        // first cached free runs the initializing flush
        send_item(OP_FREE, '0, '1, 16'd0, HDR_MARK);
        send_item(OP_FREE, '0, 48'h5, 16'd8191, HDR_MARK);
        send_item(OP_FREE, '0, 48'h7, 16'd0, HDR_MARK);
        send_item(OP_ALLOC, 32'd1, '0, '0, '0);
        send_item(OP_ALLOC, 32'd8, '0, '0, '0);
        send_item(OP_ALLOC, 32'd0, '0, '0, '0);
        send_item(OP_ALLOC, 32'd65536, '0, '0, '0);
        send_item(OP_FREE, '0, 48'h9, 16'd2, HDR_MARK);
        send_item(OP_COLLECT, '0, '0, '0, '0);
        send_item(OP_COLLECT, '1, '1, '1, '1);
        send_item(OP_ALLOC, 32'd17, '0, '0, '0);
        drain();
    endtask

    // mostly matched free and allocate traffic on a few classes, some noise
    task automatic test_random_traffic(int count, int max_cls, int collect_pct);
        int r;
        int c;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                quiet_mode = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 999);
            c = $urandom_range(0, max_cls);
            if (r < collect_pct)
                send_item(OP_COLLECT, $urandom, rand_handle(), 16'($urandom), $urandom);
            else if (r < 450)
                send_item(OP_FREE, $urandom, rand_handle(), 16'(c), HDR_MARK);
            else if (r < 850)
                send_item(OP_ALLOC, size_of_class(c), rand_handle(), 16'($urandom),
                          $urandom);
            else if (r < 880)
                send_item(OP_ALLOC, $urandom, '0, '0, '0);
            else if (r < 900)
                send_item(OP_FREE, '0, '0, 16'(c), HDR_MARK);
            else if (r < 920)
                send_item(OP_FREE, '0, rand_handle(), 16'(c), $urandom);
            else if (r < 950)
                send_item(OP_FREE, '0, rand_handle(), 16'($urandom), HDR_MARK);
            else if (r < 965)
                send_item(OP_UNUSED, $urandom, rand_handle(), 16'($urandom), $urandom);
            else
                send_item(OP_FREE, '0, rand_handle(),
                          16'($urandom_range(N_CLASSES - 8, N_CLASSES - 1)), HDR_MARK);
        end
        quiet_mode = 1'b0;
        drain();
    endtask

    // the lowest limits make nearly every free flush first
    task automatic test_low_limit();
        write_limit('0);
        test_random_traffic(8, 3, 0);
        write_limit(22'd1);
        test_random_traffic(8, 3, 0);
    endtask

    // result side stall pattern
    always @(posedge clk)
    begin
        if (out_hold > 0)
            out_hold <= out_hold - 1;
        else
        begin
            out_stall <= (!quiet_mode && $urandom_range(0, 3) == 0);
            out_hold  <= pick_gap();
        end
    end

    // result checker
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: status %0d", status);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status != want.status || out_handle != want.handle ||
                    size_class != want.size_class || block_bytes != want.bytes ||
                    cache_flushed != want.flushed ||
                    flushed_units != want.flushed_units ||
                    cached_units != want.cached_units)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected st %0d h %h cls %h by %h fl %0d fu %0d ",
                                  "cu %0d, got st %0d h %h cls %h by %h fl %0d fu %0d cu %0d"},
                                 want.status, want.handle, want.size_class, want.bytes,
                                 want.flushed, want.flushed_units, want.cached_units,
                                 status, out_handle, size_class, block_bytes,
                                 cache_flushed, flushed_units, cached_units);
                end
            end
        end
    end

    // watchdog on cycles with no item accepted on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("** size_class_free_block_cache: FAILED **");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        opcode       = '0;
        req_size     = '0;
        block_handle = '0;
        block_class  = '0;
        block_mark   = '0;
        out_stall    = 1'b0;
        out_hold     = 0;
        quiet_mode   = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;
        for (int c = 0; c < N_CLASSES; c++)
            list_head[c] = '0;
        for (int e = 0; e < N_ENTRIES; e++)
        begin
            slot_handle[e] = '0;
            slot_next[e]   = '0;
        end
        pool_head   = '0;
        units_held  = '0;
        limit_units = LIMIT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(500, 15, 4);
        write_limit(22'd200);
        test_random_traffic(300, 20, 0);
        test_low_limit();
        write_limit(22'h3F_FFFF);
        test_random_traffic(600, 12, 3);

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("** size_class_free_block_cache: PASSED **");
        else
            $display("** size_class_free_block_cache: FAILED **");
        $finish;
    end

endmodule
